>>> sv/cpi_pkg.sv
// shared types, constants and helpers of the circular arc point interpolator
`default_nettype none
package cpi_pkg;

  localparam int unsigned COORD_BITS  = 24;
  localparam int unsigned FIELD_BITS  = 24;
  localparam int unsigned RADIUS_BITS = 23;
  localparam int unsigned STEP_BITS   = 8;
  localparam int unsigned DEV_BITS    = (2 * COORD_BITS + 1 > 48) ? 2 * COORD_BITS + 1 : 48;
  localparam int unsigned QPTR_BITS   = 1;
  localparam int unsigned QUEUE_DEPTH = 1 << QPTR_BITS;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic AXIS_X  = 1'b0;
  localparam logic AXIS_Y  = 1'b1;

  typedef logic signed [FIELD_BITS-1:0]  field_t;
  typedef logic [RADIUS_BITS-1:0]        radius_t;
  typedef logic [STEP_BITS-1:0]          step_t;
  typedef logic [2*STEP_BITS-1:0]        step_sq_t;
  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic signed [COORD_BITS:0]    dist_t;
  typedef logic signed [DEV_BITS-1:0]    dev_t;
  typedef logic [COORD_BITS:0]           mag_t;

  localparam dev_t WRAP_SQ = dev_t'(1) <<< (2 * COORD_BITS);

  typedef struct packed {
    logic    is_load;
    coord_t  sx;
    coord_t  sy;
    dist_t   dx;
    dist_t   dy;
    radius_t radius;
    logic    cw;
  } req_t;

  function automatic coord_t to_coord(field_t v);
    return coord_t'(v);
  endfunction

  function automatic field_t to_field(coord_t v);
    return field_t'(v);
  endfunction

  // true when dx^2 + dy^2 < s^2
  function automatic logic near_end(dist_t a, dist_t b, step_sq_t s2);
    mag_t                 ma;
    mag_t                 mb;
    logic                 far;
    step_sq_t             sqa;
    step_sq_t             sqb;
    logic [2*STEP_BITS:0] sum;
    ma  = a[COORD_BITS] ? mag_t'(-a) : mag_t'(a);
    mb  = b[COORD_BITS] ? mag_t'(-b) : mag_t'(b);
    far = (|ma[COORD_BITS:STEP_BITS]) | (|mb[COORD_BITS:STEP_BITS]);
    sqa = ma[STEP_BITS-1:0] * ma[STEP_BITS-1:0];
    sqb = mb[STEP_BITS-1:0] * mb[STEP_BITS-1:0];
    sum = {1'b0, sqa} + {1'b0, sqb};
    return !far && (sum < {1'b0, s2});
  endfunction

endpackage
`default_nettype wire

>>> sv/cpi_intf.sv
// request, result and configuration channel interfaces
`default_nettype none
interface cpi_req_if;
  logic             valid;
  logic             ready;
  logic             operation;
  cpi_pkg::field_t  start_x;
  cpi_pkg::field_t  start_y;
  cpi_pkg::field_t  end_x;
  cpi_pkg::field_t  end_y;
  cpi_pkg::radius_t arc_radius;
  logic             clockwise;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, arc_radius,
                  clockwise, input ready);
  modport sink (input valid, operation, start_x, start_y, end_x, end_y, arc_radius,
                clockwise, output ready);
endinterface

interface cpi_res_if;
  logic            valid;
  logic            ready;
  cpi_pkg::field_t pos_x;
  cpi_pkg::field_t pos_y;
  logic            axis_moved;
  logic            move_negative;
  logic            arc_done;

  modport source (output valid, pos_x, pos_y, axis_moved, move_negative, arc_done,
                  input ready);
  modport sink (input valid, pos_x, pos_y, axis_moved, move_negative, arc_done,
                output ready);
endinterface

interface cpi_cfg_if;
  logic           valid;
  logic           ready;
  cpi_pkg::step_t step_size;

  modport source (output valid, step_size, input ready);
  modport sink (input valid, step_size, output ready);
endinterface
`default_nettype wire

>>> sv/cpi_front.sv
// request intake: decode, coordinate prep and request queue
`default_nettype none
module cpi_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  cpi_req_if.sink         req_i,
  output logic            q_valid_o,
  output cpi_pkg::req_t   q_req_o,
  input  logic            q_pop_i
);
  import cpi_pkg::*;

  req_t                 entry_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q;
  logic [QPTR_BITS-1:0] rd_ptr_q;
  logic [QPTR_BITS:0]   count_q;
  req_t                 req_in;
  coord_t               ex_c;
  coord_t               ey_c;
  logic                 push;

  always_comb begin
    ex_c           = to_coord(req_i.end_x);
    ey_c           = to_coord(req_i.end_y);
    req_in.is_load = (req_i.operation == OP_LOAD);
    req_in.sx      = to_coord(req_i.start_x);
    req_in.sy      = to_coord(req_i.start_y);
    req_in.dx      = dist_t'(req_in.sx) - dist_t'(ex_c);
    req_in.dy      = dist_t'(req_in.sy) - dist_t'(ey_c);
    req_in.radius  = req_i.arc_radius;
    req_in.cw      = req_i.clockwise;
  end

  assign req_i.ready = (count_q != (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign push        = req_i.valid && req_i.ready;
  assign q_valid_o   = (count_q != '0);
  assign q_req_o     = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= req_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, q_pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/cpi_back.sv
// arc executor: deviation tracking, move selection, end test and result register
`default_nettype none
module cpi_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  cpi_pkg::req_t q_req_i,
  output logic          q_pop_o,
  cpi_cfg_if.sink       cfg_i,
  cpi_res_if.source     res_o
);
  import cpi_pkg::*;

  step_t    step_q;
  step_sq_t step_sq_q;
  step_sq_t cfg_sq;

  coord_t cur_x_q;
  coord_t cur_y_q;
  dist_t  dx_q;
  dist_t  dy_q;
  dev_t   dev_q;
  logic   cw_q;
  logic   active_q;
  logic   ld_pend_q;

  logic signed [2*COORD_BITS-1:0] sq_x_q;
  logic signed [2*COORD_BITS-1:0] sq_y_q;
  logic [2*RADIUS_BITS-1:0]       sq_r_q;
  logic signed [2*COORD_BITS-1:0] sq_x_c;
  logic signed [2*COORD_BITS-1:0] sq_y_c;
  logic [2*RADIUS_BITS-1:0]       sq_r_c;

  logic   ov_q;
  field_t pos_x_q;
  field_t pos_y_q;
  logic   axis_q;
  logic   neg_q;
  logic   done_q;

  logic out_free;
  logic do_load;
  logic do_move;

  logic outside;
  logic x_neg, x_zero, x_pos;
  logic y_neg, y_zero, y_pos;
  logic quad1, quad2, quad3, quad4;
  logic axis_y;
  logic neg;
  logic [1:0] idx;

  dist_t step_d;
  dist_t cand_u    [4];
  logic  cand_wrap [4];
  dist_t cand_d    [4];
  logic  cand_near [4];
  dev_t  cand_corr [4];

  logic signed [COORD_BITS+STEP_BITS:0] px;
  logic signed [COORD_BITS+STEP_BITS:0] py;
  dev_t   twice_p;
  dev_t   dev_d;
  coord_t new_coord;

  // configuration
  assign cfg_i.ready = 1'b1;
  assign cfg_sq      = cfg_i.step_size * cfg_i.step_size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= step_t'(1);
      step_sq_q <= step_sq_t'(1);
    end else if (cfg_i.valid) begin
      step_q    <= cfg_i.step_size;
      step_sq_q <= cfg_sq;
    end
  end

  // request scheduling
  assign out_free = !ov_q || res_o.ready;
  assign q_pop_o  = q_valid_i && !ld_pend_q && (q_req_i.is_load || !active_q || out_free);
  assign do_load  = q_pop_o && q_req_i.is_load;
  assign do_move  = q_pop_o && !q_req_i.is_load && active_q;

  // move decision
  always_comb begin
    outside = !dev_q[DEV_BITS-1];
    x_neg   = cur_x_q[COORD_BITS-1];
    x_zero  = (cur_x_q == '0);
    x_pos   = !x_neg && !x_zero;
    y_neg   = cur_y_q[COORD_BITS-1];
    y_zero  = (cur_y_q == '0);
    y_pos   = !y_neg && !y_zero;
    quad1   = (x_pos && !y_neg) || (x_zero && y_zero);
    quad2   = !x_pos && y_pos;
    quad3   = x_neg && !y_pos;
    quad4   = !x_neg && y_neg;
    axis_y  = (outside != cw_q) ? (quad2 || quad4) : (quad1 || quad3);
    if (outside) begin
      neg = cw_q ? (quad1 || quad4) : (quad1 || quad2);
    end else begin
      neg = cw_q ? (quad3 || quad4) : (quad2 || quad3);
    end
    idx = {axis_y, neg};
  end

  // all four candidate moves, index is {axis, negative}
  assign step_d = dist_t'({1'b0, step_q});

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cand_u[k]    = (k[1] ? dist_t'(cur_y_q) : dist_t'(cur_x_q)) + (k[0] ? -step_d : step_d);
      cand_wrap[k] = cand_u[k][COORD_BITS] ^ cand_u[k][COORD_BITS-1];
      cand_d[k]    = (k[1] ? dy_q : dx_q) + (k[0] ? -step_d : step_d);
      cand_d[k][COORD_BITS] = cand_d[k][COORD_BITS] ^ cand_wrap[k];
      cand_near[k] = k[1] ? near_end(dx_q, cand_d[k], step_sq_q)
                          : near_end(cand_d[k], dy_q, step_sq_q);
      if (!cand_wrap[k]) begin
        cand_corr[k] = '0;
      end else if (cand_u[k][COORD_BITS]) begin
        cand_corr[k] = WRAP_SQ + (dev_t'(cand_u[k]) <<< (COORD_BITS + 1));
      end else begin
        cand_corr[k] = WRAP_SQ - (dev_t'(cand_u[k]) <<< (COORD_BITS + 1));
      end
    end
  end

  // deviation update: f + s^2 +/- 2*s*v + wrap correction
  assign px = cur_x_q * $signed({1'b0, step_q});
  assign py = cur_y_q * $signed({1'b0, step_q});

  always_comb begin
    twice_p   = (axis_y ? dev_t'(py) : dev_t'(px)) <<< 1;
    dev_d     = dev_q + dev_t'(step_sq_q) + (neg ? -twice_p : twice_p) + cand_corr[idx];
    new_coord = cand_u[idx][COORD_BITS-1:0];
  end

  // load squaring
  assign sq_x_c = q_req_i.sx * q_req_i.sx;
  assign sq_y_c = q_req_i.sy * q_req_i.sy;
  assign sq_r_c = q_req_i.radius * q_req_i.radius;

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      cur_x_q <= q_req_i.sx;
      cur_y_q <= q_req_i.sy;
      dx_q    <= q_req_i.dx;
      dy_q    <= q_req_i.dy;
      cw_q    <= q_req_i.cw;
      sq_x_q  <= sq_x_c;
      sq_y_q  <= sq_y_c;
      sq_r_q  <= sq_r_c;
    end else if (do_move) begin
      if (axis_y == AXIS_Y) begin
        cur_y_q <= new_coord;
        dy_q    <= cand_d[idx];
      end else begin
        cur_x_q <= new_coord;
        dx_q    <= cand_d[idx];
      end
    end
    if (ld_pend_q) begin
      dev_q <= dev_t'(sq_x_q) + dev_t'(sq_y_q) - dev_t'(sq_r_q);
    end else if (do_move) begin
      dev_q <= dev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      ld_pend_q <= 1'b0;
    end else begin
      ld_pend_q <= do_load;
      if (do_load) begin
        active_q <= 1'b1;
      end else if (do_move) begin
        active_q <= !cand_near[idx];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (do_move) begin
      pos_x_q <= to_field((axis_y == AXIS_Y) ? cur_x_q : new_coord);
      pos_y_q <= to_field((axis_y == AXIS_Y) ? new_coord : cur_y_q);
      axis_q  <= axis_y;
      neg_q   <= neg;
      done_q  <= cand_near[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (do_move) begin
      ov_q <= 1'b1;
    end else if (res_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  assign res_o.valid         = ov_q;
  assign res_o.pos_x         = pos_x_q;
  assign res_o.pos_y         = pos_y_q;
  assign res_o.axis_moved    = axis_q;
  assign res_o.move_negative = neg_q;
  assign res_o.arc_done      = done_q;

endmodule
`default_nettype wire

>>> sv/circular_arc_point_interpolator_unit.sv
// top level of the circular arc point interpolator
//
//  channel  dir  handshake     carries
//  req_i    in   valid/ready   operation, start/end point, radius, direction
//  cfg_i    in   valid/ready   step_size
//  res_o    out  valid/ready   new point, axis, direction, done mark
//
// one tick request per cycle while the result is taken and no load is pending; a tick
// result appears in the cycle after it leaves the two-entry request queue
// a load occupies the executor while it squares start and radius, then forms the
// deviation sum; the next tick starts after that
// the point and deviation registers are updated once per move
// reset clears queue, active arc flag and result valid; step_size returns to 1
// a stalled result holds its register; loads still drain, ticks of an active arc wait in the queue
`default_nettype none
module circular_arc_point_interpolator_unit (
  input  logic clk_i,
  input  logic rst_ni,
  cpi_req_if.sink   req_i,
  cpi_cfg_if.sink   cfg_i,
  cpi_res_if.source res_o
);
  import cpi_pkg::*;

  logic q_valid;
  req_t q_req;
  logic q_pop;

  cpi_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_req_o   (q_req),
    .q_pop_i   (q_pop)
  );

  cpi_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_req_i   (q_req),
    .q_pop_o   (q_pop),
    .cfg_i     (cfg_i),
    .res_o     (res_o)
  );

endmodule
`default_nettype wire

>>> sv/cpi_checker.sv
// port-level checks of the interpolator and their binding
`default_nettype none
module cpi_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            res_valid_i,
  input logic            res_ready_i,
  input cpi_pkg::field_t pos_x_i,
  input cpi_pkg::field_t pos_y_i,
  input logic            axis_moved_i,
  input logic            arc_done_i
);
  import cpi_pkg::*;

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // back-to-back moves of one arc keep the other coordinate
  a_x_move_keeps_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_ready_i) ##1 (res_valid_i && res_ready_i && !arc_done_i)
      ##1 (res_valid_i && (axis_moved_i == AXIS_X))
    |-> pos_y_i == $past(pos_y_i))
    else $error("x move changed y");

  a_y_move_keeps_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_ready_i) ##1 (res_valid_i && res_ready_i && !arc_done_i)
      ##1 (res_valid_i && (axis_moved_i == AXIS_Y))
    |-> pos_x_i == $past(pos_x_i))
    else $error("y move changed x");

endmodule

bind circular_arc_point_interpolator_unit cpi_checker u_cpi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .pos_x_i      (res_o.pos_x),
  .pos_y_i      (res_o.pos_y),
  .axis_moved_i (res_o.axis_moved),
  .arc_done_i   (res_o.arc_done)
);
`default_nettype wire
